[rtl/core/pidl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_pkg
// Types and codes shared by the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int unsigned LEN_W  = 7;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned WORD_W = 32;

    typedef enum logic [2:0] {
        A_CREATE = 3'd0,
        A_LOAD   = 3'd1,
        A_INSERT = 3'd2,
        A_DELETE = 3'd3,
        A_SHOW   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_CREATED  = 3'd1,
        ST_BAD_POSITION = 3'd2,
        ST_FULL         = 3'd3,
        ST_EMPTY        = 3'd4,
        ST_LOADING      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        C_NOP,
        C_INSERT,
        C_ROTATE,
        C_POP
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_POP,
        S_POST,
        S_SHOW
    } state_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  data;
        logic [POS_W-1:0]          index;
        logic                      last;
    } res_t;

endpackage

[rtl/core/pidl_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_req_if
// Command channel of the list: action, length, position and value.
// ----------------------------------------------------------------------------
interface pidl_req_if;

    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [6:0]        length;
    logic [5:0]        position;
    logic signed [31:0] value;

    modport source (
        output valid,
        output action,
        output length,
        output position,
        output value,
        input  ready
    );

    modport sink (
        input  valid,
        input  action,
        input  length,
        input  position,
        input  value,
        output ready
    );

endinterface

[rtl/core/pidl_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_rsp_if
// Result channel of the list: status, data, index and last.
// ----------------------------------------------------------------------------
interface pidl_rsp_if;

    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [5:0]         index;
    logic               last;

    modport source (
        output valid,
        output status,
        output data,
        output index,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  data,
        input  index,
        input  last,
        output ready
    );

endinterface

[rtl/core/pidl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word, takes a new value, a neighbor's word or the head word.
// ----------------------------------------------------------------------------
module pidl_cell
    import pidl_pkg::*;
#(
    parameter int unsigned CW  = 7,
    parameter int unsigned IDX = 0
)
(
    input  logic                     clk,
    input  cell_op_t                 op,
    input  logic [CW-1:0]            pos,
    input  logic [CW-1:0]            cnt,
    input  logic signed [WORD_W-1:0] value,
    input  logic signed [WORD_W-1:0] left,
    input  logic signed [WORD_W-1:0] right,
    input  logic signed [WORD_W-1:0] head,
    output logic signed [WORD_W-1:0] entry
);

    localparam logic [CW-1:0] SELF = CW'(IDX);
    localparam logic [CW-1:0] NEXT = CW'(IDX + 1);

    logic signed [WORD_W-1:0] entry_reg;
    logic signed [WORD_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (op)
            C_INSERT:
            begin
                if (SELF == pos)
                begin
                    entry_next = value;
                end
                else if (SELF > pos && SELF <= cnt)
                begin
                    entry_next = left;
                end
            end
            C_ROTATE:
            begin
                if (NEXT < cnt)
                begin
                    entry_next = right;
                end
                else if (NEXT == cnt)
                begin
                    entry_next = head;
                end
            end
            C_POP:
            begin
                if (NEXT < cnt)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

[rtl/core/positional_insert_delete_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words kept in a chain of cells; create, load,
// insert, delete and display commands with status on every result.
//
//   channel   dir   beat
//   req       in    action, length, position, value
//   rsp       out   status, data, index, last
//
// create, load, insert and error results: registered when the command is accepted
// delete: the chain rotates the word to cell 0, pops it, then rotates
//   the rest back
// display: after the accept, count beats, one per cycle while rsp does not
//   stall, as the chain rotates
// reset clears count, created and loads_reg; cell words need no reset
// a stalled rsp holds the result register and the next command waits
// ----------------------------------------------------------------------------
module positional_insert_delete_list
    import pidl_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    pidl_req_if.sink   req,
    pidl_rsp_if.source rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     created_reg, created_next;
    logic [LEN_W-1:0]         loads_reg, loads_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [CW-1:0]            pos_reg, pos_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    logic                     out_valid_reg, out_valid_next;
    res_t                     res_reg, res_next;

    cell_op_t                 cell_op;
    logic [CW-1:0]            cell_pos;
    logic [CW-1:0]            cell_cnt;
    logic signed [WORD_W-1:0] cell_q [CAPACITY];
    logic signed [WORD_W-1:0] head;

    logic                     slot_free;
    logic                     req_ready;
    logic [CW-1:0]            k_inc;
    logic [CW-1:0]            rem;
    logic [31:0]              len32;
    logic [31:0]              pos32;
    logic [31:0]              cnt32;

    assign head      = cell_q[0];
    assign slot_free = !out_valid_reg || rsp.ready;
    assign req_ready = (state_reg == S_IDLE) && slot_free;
    assign k_inc     = k_reg + CW'(1);
    assign rem       = count_reg - CW'(1) - pos_reg;
    assign len32     = 32'(req.length);
    assign pos32     = 32'(req.position);
    assign cnt32     = 32'(count_reg);

    // cell chain
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [WORD_W-1:0] left_d;
            logic signed [WORD_W-1:0] right_d;
            if (g == 0)
            begin : g_first
                assign left_d = cell_q[g];
            end
            else
            begin : g_mid_l
                assign left_d = cell_q[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_q[g];
            end
            else
            begin : g_mid_r
                assign right_d = cell_q[g+1];
            end
            pidl_cell #(
                .CW  (CW),
                .IDX (g)
            ) u_cell (
                .clk   (clk),
                .op    (cell_op),
                .pos   (cell_pos),
                .cnt   (cell_cnt),
                .value (req.value),
                .left  (left_d),
                .right (right_d),
                .head  (head),
                .entry (cell_q[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        created_next   = created_reg;
        loads_next     = loads_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        res_next       = res_reg;
        cell_op        = C_NOP;
        cell_pos       = count_reg;
        cell_cnt       = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req_ready)
                begin
                    res_next = '{status: ST_OK, data: '0, index: '0, last: 1'b1};
                    out_valid_next = 1'b1;
                    case (action_t'(req.action))
                        A_CREATE:
                        begin
                            if (len32 > 32'(CAPACITY))
                            begin
                                res_next.status = ST_BAD_POSITION;
                            end
                            else
                            begin
                                count_next   = '0;
                                created_next = 1'b1;
                                loads_next   = req.length;
                            end
                        end
                        A_LOAD:
                        begin
                            if (!created_reg)
                            begin
                                res_next.status = ST_NOT_CREATED;
                            end
                            else if (loads_reg == '0 || cnt32 >= 32'(CAPACITY))
                            begin
                                res_next.status = ST_BAD_POSITION;
                            end
                            else
                            begin
                                cell_op        = C_INSERT;
                                cell_pos       = count_reg;
                                res_next.index = POS_W'(count_reg);
                                count_next     = count_reg + CW'(1);
                                loads_next     = loads_reg - LEN_W'(1);
                            end
                        end
                        A_INSERT, A_DELETE, A_SHOW:
                        begin
                            if (!created_reg)
                            begin
                                res_next.status = ST_NOT_CREATED;
                            end
                            else if (loads_reg != '0)
                            begin
                                res_next.status = ST_LOADING;
                            end
                            else if (action_t'(req.action) == A_INSERT)
                            begin
                                if (cnt32 >= 32'(CAPACITY))
                                begin
                                    res_next.status = ST_FULL;
                                end
                                else if (pos32 > cnt32)
                                begin
                                    res_next.status = ST_BAD_POSITION;
                                end
                                else
                                begin
                                    cell_op        = C_INSERT;
                                    cell_pos       = CW'(req.position);
                                    res_next.index = req.position;
                                    count_next     = count_reg + CW'(1);
                                end
                            end
                            else if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else if (action_t'(req.action) == A_DELETE)
                            begin
                                if (pos32 >= cnt32)
                                begin
                                    res_next.status = ST_BAD_POSITION;
                                end
                                else
                                begin
                                    out_valid_next = 1'b0;
                                    pos_next       = CW'(req.position);
                                    k_next         = '0;
                                    state_next     = (req.position == '0) ? S_POP : S_PRE;
                                end
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                k_next         = '0;
                                state_next     = S_SHOW;
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !rsp.ready;
                        end
                    endcase
                end
            end
            S_PRE:
            begin
                // bring the doomed word to cell 0
                cell_op = C_ROTATE;
                k_next  = k_inc;
                if (k_inc == pos_reg)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cell_op    = C_POP;
                word_next  = head;
                count_next = count_reg - CW'(1);
                k_next     = rem;
                if (rem == '0)
                begin
                    res_next = '{status: ST_OK, data: head, index: POS_W'(pos_reg),
                                 last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                // rotate the remaining words back into order
                cell_op = C_ROTATE;
                k_next  = k_reg - CW'(1);
                if (k_reg == CW'(1))
                begin
                    res_next = '{status: ST_OK, data: word_reg, index: POS_W'(pos_reg),
                                 last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SHOW:
            begin
                if (slot_free)
                begin
                    cell_op  = C_ROTATE;
                    res_next = '{status: ST_OK, data: head, index: POS_W'(k_reg),
                                 last: (k_inc == count_reg)};
                    out_valid_next = 1'b1;
                    k_next         = k_inc;
                    if (k_inc == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            created_reg   <= 1'b0;
            loads_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            created_reg   <= created_next;
            loads_reg     <= loads_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        word_reg <= word_next;
        res_reg  <= res_next;
    end

    assign req.ready  = req_ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = res_reg.status;
    assign rsp.data   = res_reg.data;
    assign rsp.index  = res_reg.index;
    assign rsp.last   = res_reg.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(CAPACITY))
        else $error("count above capacity");

    a_loads_created: assert property (@(posedge clk) disable iff (!rst_n)
        loads_reg != '0 |-> created_reg)
        else $error("loads pending without create");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not shrink the list");

    a_post_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PRE || state_reg == S_POP || state_reg == S_POST)
            |-> !out_valid_reg)
        else $error("result pending during delete");

    a_show_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHOW |-> k_reg < count_reg)
        else $error("display index past count");

endmodule
